### rtl/ptt_pkg.sv
// Shared types and codes for the periodic timer table.
package ptt_pkg;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_CREATE = 2'd1,
    FN_CANCEL = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_ROT,
    ST_DONE
  } state_t;

  // Row operation applied to every cell in the same cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_KEEP,
    CELL_DROP,
    CELL_APPEND
  } cell_op_t;

  // Remaining count meaning "repeat forever".
  localparam logic signed [16:0] REM_FOREVER = 17'h1FFFF;

  typedef struct packed {
    logic [31:0]        interval;
    logic [63:0]        due;
    logic signed [16:0] remaining;
    logic [7:0]         handler;
    logic [63:0]        tag;
    logic [7:0]         task_id;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    entry_t   head;
    entry_t   fresh;
  } cell_ctl_t;

endpackage

### rtl/ptt_cell.sv
// One cell of the age-ordered timer row.
module ptt_cell
  import ptt_pkg::*;
#(
  parameter int SLOT_W = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [SLOT_W-1:0] head_slot,
  input  logic [SLOT_W-1:0] fresh_slot,
  input  logic              prev_v,
  input  logic              next_v,
  input  entry_t            next_d,
  input  logic [SLOT_W-1:0] next_s,
  output logic              v,
  output entry_t            d,
  output logic [SLOT_W-1:0] s
);

  logic              v_r, v_nxt;
  entry_t            d_r, d_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;

  always_comb begin
    v_nxt = v_r;
    d_nxt = d_r;
    s_nxt = s_r;
    unique case (ctl.op)
      CELL_KEEP: begin
        // Shift down; the last live cell takes the head.
        if (v_r) begin
          if (next_v) begin
            d_nxt = next_d;
            s_nxt = next_s;
          end else begin
            d_nxt = ctl.head;
            s_nxt = head_slot;
          end
        end
      end
      CELL_DROP: begin
        if (v_r) begin
          d_nxt = next_d;
          s_nxt = next_s;
          v_nxt = next_v;
        end
      end
      CELL_APPEND: begin
        if (!v_r && prev_v) begin
          d_nxt = ctl.fresh;
          s_nxt = fresh_slot;
          v_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
    s_r <= s_nxt;
  end

  assign v = v_r;
  assign d = d_r;
  assign s = s_r;

endmodule

### rtl/periodic_timer_table.sv
// Periodic timer table: sequencer and the age-ordered row of timer cells.
//
//   channel | direction | fields
//   in_     | input     | func interval repeat_count handler tag task_req slot
//   out_    | output    | fired fired_slot fired_handler fired_tag fired_task status new_slot
//
// Tick and cancel rotate the row once per cycle through the head cell until the
// oldest entry is back in front.
// Create searches the slot bitmap one bit a cycle, unless the table is already full.
// Reset clears the tick counter, the cell valid bits and the slot bitmap.
// A finished result waits in the output register; the next item is taken meanwhile.
module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_interval,
  input  logic [16:0] in_repeat_count,
  input  logic [7:0]  in_handler,
  input  logic [63:0] in_tag,
  input  logic [7:0]  in_task_req,
  input  logic [3:0]  in_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fired,
  output logic [3:0]  out_fired_slot,
  output logic [7:0]  out_fired_handler,
  output logic [63:0] out_fired_tag,
  output logic [7:0]  out_fired_task,
  output logic [1:0]  out_status,
  output logic [3:0]  out_new_slot
);

  localparam int SW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int SXW = (SW > 4) ? SW : 4;
  localparam int XW  = (CW > 4) ? CW : 4;

  state_t              state_r, state_nxt;
  logic [63:0]         tick_r, tick_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [CW-1:0]       rot_r, rot_nxt;
  logic [SW-1:0]       srch_r, srch_nxt;
  logic [SW-1:0]       cslot_r, cslot_nxt;
  logic                armed_r, armed_nxt;
  logic                cmode_r, cmode_nxt;
  logic [ENTRIES-1:0]  inuse_r, inuse_nxt;
  entry_t              fresh_r, fresh_nxt;

  logic                res_fired_r, res_fired_nxt;
  logic [3:0]          res_fslot_r, res_fslot_nxt;
  logic [7:0]          res_handler_r, res_handler_nxt;
  logic [63:0]         res_tag_r, res_tag_nxt;
  logic [7:0]          res_task_r, res_task_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [3:0]          res_nslot_r, res_nslot_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                o_fired_r, o_fired_nxt;
  logic [3:0]          o_fslot_r, o_fslot_nxt;
  logic [7:0]          o_handler_r, o_handler_nxt;
  logic [63:0]         o_tag_r, o_tag_nxt;
  logic [7:0]          o_task_r, o_task_nxt;
  logic [1:0]          o_status_r, o_status_nxt;
  logic [3:0]          o_nslot_r, o_nslot_nxt;

  cell_ctl_t           ctl;
  logic [SW-1:0]       fresh_slot;
  logic                cell_v [ENTRIES];
  entry_t              cell_d [ENTRIES];
  logic [SW-1:0]       cell_s [ENTRIES];

  entry_t              head;
  entry_t              head_upd;
  logic                head_live;
  logic [SXW-1:0]      head_sx;
  logic [SXW-1:0]      srch_sx;
  logic [XW-1:0]       in_slot_x;
  logic [SW-1:0]       in_slot_i;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      logic          pv;
      logic          nv;
      entry_t        nd;
      logic [SW-1:0] ns;
      if (gi == 0) begin : g_first
        assign pv = 1'b1;
      end else begin : g_mid
        assign pv = cell_v[gi-1];
      end
      if (gi == ENTRIES - 1) begin : g_last
        assign nv = 1'b0;
        assign nd = '0;
        assign ns = '0;
      end else begin : g_inner
        assign nv = cell_v[gi+1];
        assign nd = cell_d[gi+1];
        assign ns = cell_s[gi+1];
      end
      ptt_cell #(.SLOT_W(SW)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .head_slot  (cell_s[0]),
        .fresh_slot (fresh_slot),
        .prev_v     (pv),
        .next_v     (nv),
        .next_d     (nd),
        .next_s     (ns),
        .v          (cell_v[gi]),
        .d          (cell_d[gi]),
        .s          (cell_s[gi])
      );
    end
  endgenerate

  assign head      = cell_d[0];
  assign head_live = (head.remaining == REM_FOREVER) || (head.remaining > 17'sd0);
  assign head_sx   = SXW'(cell_s[0]);
  assign srch_sx   = SXW'(srch_r);
  assign in_slot_x = XW'(in_slot);
  assign in_slot_i = SW'(in_slot_x);
  assign fresh_slot = srch_r;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    head_upd     = head;
    if (head.remaining != REM_FOREVER) begin
      head_upd.remaining = head.remaining - 17'sd1;
    end
    head_upd.due = head.due + 64'(head.interval);
  end

  always_comb begin
    state_nxt       = state_r;
    tick_nxt        = tick_r;
    n_nxt           = n_r;
    rot_nxt         = rot_r;
    srch_nxt        = srch_r;
    cslot_nxt       = cslot_r;
    armed_nxt       = armed_r;
    cmode_nxt       = cmode_r;
    inuse_nxt       = inuse_r;
    fresh_nxt       = fresh_r;
    res_fired_nxt   = res_fired_r;
    res_fslot_nxt   = res_fslot_r;
    res_handler_nxt = res_handler_r;
    res_tag_nxt     = res_tag_r;
    res_task_nxt    = res_task_r;
    res_status_nxt  = res_status_r;
    res_nslot_nxt   = res_nslot_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    o_fired_nxt     = o_fired_r;
    o_fslot_nxt     = o_fslot_r;
    o_handler_nxt   = o_handler_r;
    o_tag_nxt       = o_tag_r;
    o_task_nxt      = o_task_r;
    o_status_nxt    = o_status_r;
    o_nslot_nxt     = o_nslot_r;
    ctl.op          = CELL_HOLD;
    ctl.head        = head;
    ctl.fresh       = fresh_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_fired_nxt   = 1'b0;
          res_fslot_nxt   = '0;
          res_handler_nxt = '0;
          res_tag_nxt     = '0;
          res_task_nxt    = '0;
          res_status_nxt  = STAT_OK;
          res_nslot_nxt   = '0;
          rot_nxt         = n_r;
          unique case (func_t'(in_func))
            FN_TICK: begin
              tick_nxt  = tick_r + 64'd1;
              armed_nxt = 1'b1;
              cmode_nxt = 1'b0;
              state_nxt = (n_r == '0) ? ST_DONE : ST_ROT;
            end
            FN_CREATE: begin
              fresh_nxt.interval  = in_interval;
              fresh_nxt.due       = tick_r + 64'(in_interval) - 64'd1;
              fresh_nxt.remaining = in_repeat_count;
              fresh_nxt.handler   = in_handler;
              fresh_nxt.tag       = in_tag;
              fresh_nxt.task_id   = in_task_req;
              srch_nxt            = '0;
              if (n_r == CW'(ENTRIES)) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_SRCH;
              end
            end
            FN_CANCEL: begin
              if (in_slot_x < XW'(ENTRIES) && inuse_r[in_slot_i]) begin
                cslot_nxt = in_slot_i;
                cmode_nxt = 1'b1;
                state_nxt = ST_ROT;
              end else begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = ST_DONE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SRCH: begin
        if (!inuse_r[srch_r]) begin
          ctl.op            = CELL_APPEND;
          inuse_nxt[srch_r] = 1'b1;
          n_nxt             = n_r + CW'(1);
          res_nslot_nxt     = srch_sx[3:0];
          state_nxt         = ST_DONE;
        end else begin
          srch_nxt = srch_r + SW'(1);
        end
      end
      ST_ROT: begin
        ctl.op = CELL_KEEP;
        if (cmode_r) begin
          if (cell_s[0] == cslot_r) begin
            ctl.op = CELL_DROP;
          end
        end else if (armed_r) begin
          if (!head_live) begin
            ctl.op = CELL_DROP;
          end else if (tick_r > head.due) begin
            // Fire, then let the rest pass through unexamined.
            ctl.head        = head_upd;
            armed_nxt       = 1'b0;
            res_fired_nxt   = 1'b1;
            res_fslot_nxt   = head_sx[3:0];
            res_handler_nxt = head.handler;
            res_tag_nxt     = head.tag;
            res_task_nxt    = head.task_id;
          end
        end
        if (ctl.op == CELL_DROP) begin
          inuse_nxt[cell_s[0]] = 1'b0;
          n_nxt                = n_r - CW'(1);
        end
        rot_nxt = rot_r - CW'(1);
        if (rot_r == CW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_fired_nxt   = res_fired_r;
          o_fslot_nxt   = res_fslot_r;
          o_handler_nxt = res_handler_r;
          o_tag_nxt     = res_tag_r;
          o_task_nxt    = res_task_r;
          o_status_nxt  = res_status_r;
          o_nslot_nxt   = res_nslot_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_r      <= '0;
      n_r         <= '0;
      inuse_r     <= '0;
      out_valid_r <= 1'b0;
      armed_r     <= 1'b0;
      cmode_r     <= 1'b0;
      rot_r       <= '0;
      srch_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      n_r         <= n_nxt;
      inuse_r     <= inuse_nxt;
      out_valid_r <= out_valid_nxt;
      armed_r     <= armed_nxt;
      cmode_r     <= cmode_nxt;
      rot_r       <= rot_nxt;
      srch_r      <= srch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cslot_r       <= cslot_nxt;
    fresh_r       <= fresh_nxt;
    res_fired_r   <= res_fired_nxt;
    res_fslot_r   <= res_fslot_nxt;
    res_handler_r <= res_handler_nxt;
    res_tag_r     <= res_tag_nxt;
    res_task_r    <= res_task_nxt;
    res_status_r  <= res_status_nxt;
    res_nslot_r   <= res_nslot_nxt;
    o_fired_r     <= o_fired_nxt;
    o_fslot_r     <= o_fslot_nxt;
    o_handler_r   <= o_handler_nxt;
    o_tag_r       <= o_tag_nxt;
    o_task_r      <= o_task_nxt;
    o_status_r    <= o_status_nxt;
    o_nslot_r     <= o_nslot_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_fired         = o_fired_r;
  assign out_fired_slot    = o_fslot_r;
  assign out_fired_handler = o_handler_r;
  assign out_fired_tag     = o_tag_r;
  assign out_fired_task    = o_task_r;
  assign out_status        = o_status_r;
  assign out_new_slot      = o_nslot_r;

  a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(ENTRIES))
    else $error("live entry count exceeds table depth");

  a_bitmap_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(inuse_r) == int'(n_r))
    else $error("slot bitmap disagrees with live entry count");

  a_head_live_in_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROT |-> cell_v[0])
    else $error("rotation reached an empty head cell");

  a_rot_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROT |-> (rot_r != '0 && rot_r <= n_r))
    else $error("rotation count out of step with live entries");

endmodule
